// ===== rtl/yafp_pkg.sv =====
// ----------------------------------------------------------------------------
// yafp_pkg - shared definitions for the YUV alpha fade pixel pipeline
// Colour conversion coefficients and the small arithmetic helpers that the
// pipeline stages use.
// ----------------------------------------------------------------------------
package yafp_pkg;

  // Width of the signed accumulators of the YUV to RGB conversion.
  localparam int unsigned SumW = 20;
  // Width of the signed accumulators of the RGB to YUV conversion.
  localparam int unsigned BackW = 19;

  typedef logic signed [SumW-1:0]  sum_t;
  typedef logic signed [BackW-1:0] back_t;
  typedef logic [7:0]              byte_t;
  typedef logic [15:0]             prod_t;

  // YUV to RGB coefficients.
  localparam sum_t KYuvD   = 20'sd298;
  localparam sum_t KRf     = 20'sd411;
  localparam sum_t KRoff   = 20'sd32;
  localparam sum_t KGe     = 20'sd101;
  localparam sum_t KGf     = 20'sd211;
  localparam sum_t KGoff   = 20'sd429;
  localparam sum_t KBe     = 20'sd519;
  localparam sum_t KBoff   = 20'sd83;

  // RGB to YUV coefficients.
  localparam back_t KYr    = 19'sd66;
  localparam back_t KYg    = 19'sd129;
  localparam back_t KYb    = 19'sd25;
  localparam back_t KUr    = 19'sd38;
  localparam back_t KUg    = 19'sd74;
  localparam back_t KUVbig = 19'sd112;
  localparam back_t KVg    = 19'sd94;
  localparam back_t KVb    = 19'sd18;
  localparam back_t KOffY  = 19'sd16;
  localparam back_t KOffC  = 19'sd128;

  // Floor divide by 256, then saturate to a byte.
  function automatic byte_t clamp_shr8(input sum_t sum);
    sum_t sh;
    byte_t res;
    sh = sum >>> 8;
    if (sh < 0) begin
      res = 8'd0;
    end else if (sh > 20'sd255) begin
      res = 8'd255;
    end else begin
      res = sh[7:0];
    end
    return res;
  endfunction

  // Exact x / 255 for x up to 255 * 255: (x + 1 + (x >> 8)) >> 8.
  function automatic byte_t div255(input prod_t x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

  // Zero-extend an unsigned byte into the back-conversion width.
  function automatic back_t ext_back(input byte_t v);
    return back_t'({11'd0, v});
  endfunction

endpackage

// ===== rtl/yuv_alpha_fade_pixel.sv =====
// ----------------------------------------------------------------------------
// yuv_alpha_fade_pixel - brightness fade of a YUV pixel stream
// Converts each pixel to RGB, scales the channels by alpha / 255 and converts
// the result back to YUV in four pipeline stages, one pixel per clock unless stalled.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock unless stalled and returns one faded
// pixel per pixel, in order. A pixel taken at the input passes through each
// register stage in turn and is offered on the output from the last one until
// the output side is ready. The four register stages are: the YUV to RGB sums,
// the clamp and the alpha multiply, the divide by 255, and the RGB to YUV
// conversion, which is also the output register. Each stage holds its beat
// until the next stage has room, so a stall on the output side only stops the
// input once every stage is full. fade_alpha is written through fade_alpha_we_i
// and should only be changed while no pixel is in flight; it resets to 255 (no
// fade). The outputs always lie within 16..239.
module yuv_alpha_fade_pixel
  import yafp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        fade_alpha_we_i,
  input  logic [7:0]  fade_alpha_i,
  // Input pixel stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // luma_in [7:0], cb_in [15:8], cr_in [23:16]
  // Output pixel stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // luma_out [7:0], cb_out [15:8], cr_out [23:16]
);

  // Configuration register.
  logic [7:0] fade_alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_alpha_q <= 8'd255;
    end else if (fade_alpha_we_i) begin
      fade_alpha_q <= fade_alpha_i;
    end
  end

  // Stage valid bits and the ready chain. A stage takes a new beat when it is
  // empty or when the stage after it takes its current beat.
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Stage 1: the unshifted R, G and B sums from the offset-removed samples.
  sum_t d_s, e_s, f_s;
  sum_t r_sum_d, g_sum_d, b_sum_d;
  sum_t r_sum_q, g_sum_q, b_sum_q;

  always_comb begin
    d_s = sum_t'({12'd0, s_axis_tdata[7:0]})   - 20'sd16;
    e_s = sum_t'({12'd0, s_axis_tdata[15:8]})  - 20'sd128;
    f_s = sum_t'({12'd0, s_axis_tdata[23:16]}) - 20'sd128;
    r_sum_d = KYuvD * d_s + KRf * f_s + KRoff;
    g_sum_d = KYuvD * d_s - KGe * e_s - KGf * f_s - KGoff;
    b_sum_d = KYuvD * d_s + KBe * e_s + KBoff;
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      r_sum_q <= r_sum_d;
      g_sum_q <= g_sum_d;
      b_sum_q <= b_sum_d;
    end
  end

  // Stage 2: clamp each channel to a byte and multiply it by alpha.
  prod_t r_prod_q, g_prod_q, b_prod_q;

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      r_prod_q <= prod_t'(clamp_shr8(r_sum_q)) * prod_t'(fade_alpha_q);
      g_prod_q <= prod_t'(clamp_shr8(g_sum_q)) * prod_t'(fade_alpha_q);
      b_prod_q <= prod_t'(clamp_shr8(b_sum_q)) * prod_t'(fade_alpha_q);
    end
  end

  // Stage 3: the truncating divide by 255.
  byte_t r_q, g_q, b_q;

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      r_q <= div255(r_prod_q);
      g_q <= div255(g_prod_q);
      b_q <= div255(b_prod_q);
    end
  end

  // Stage 4: back to YUV with flooring shifts and offsets.
  back_t r_b, g_b, b_b;
  back_t y_acc, u_acc, v_acc;
  byte_t y_d, u_d, v_d;
  byte_t y_q, u_q, v_q;

  always_comb begin
    r_b   = ext_back(r_q);
    g_b   = ext_back(g_q);
    b_b   = ext_back(b_q);
    y_acc = ((KYr * r_b + KYg * g_b + KYb * b_b) >>> 8) + KOffY;
    u_acc = ((KUVbig * b_b - KUr * r_b - KUg * g_b) >>> 8) + KOffC;
    v_acc = ((KUVbig * r_b - KVg * g_b - KVb * b_b) >>> 8) + KOffC;
    y_d   = y_acc[7:0];
    u_d   = u_acc[7:0];
    v_d   = v_acc[7:0];
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      y_q <= y_d;
      u_q <= u_d;
      v_q <= v_d;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {v_q, u_q, y_q};

  // An empty output stage leaves room all the way back to the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v4_q |-> s_axis_tready)
    else $error("input not ready although the output stage is empty");

  // The back conversion of clamped channels never leaves 16..239.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> (y_q >= 8'd16 && y_q <= 8'd239))
    else $error("faded luma out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> (u_q >= 8'd16 && u_q <= 8'd240 && v_q >= 8'd16 && v_q <= 8'd240))
    else $error("faded chroma out of range");

  // A beat in stage 1 reaches stage 2 on the next edge when stage 2 has room.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && rdy2) |=> v2_q)
    else $error("beat lost between the first and second stages");

endmodule
